// ----- rtl/lsbr_pkg.sv -----
package lsbr_pkg;

	// Operation codes of a request word
	typedef logic [1:0] op_t;
	localparam op_t OP_PUSH  = 2'd0;
	localparam op_t OP_READ  = 2'd1;
	localparam op_t OP_ALIGN = 2'd2;

	localparam int BYTE_BITS        = 8;
	localparam int MAX_FIELD        = 32;
	localparam int LSBR_BUFFER_BITS = 64;

	// Result word handed from the datapath to the output register
	typedef struct packed {
		logic [31:0] value;
		logic        ok;
	} rsp_t;

endpackage

// ----- rtl/lsbr_if.sv -----
interface lsbr_req_if;
	import lsbr_pkg::*;

	logic       valid;
	logic       ready;
	op_t        op;
	logic [7:0] data_byte;
	logic [5:0] bit_count;

	modport source (output valid, output op, output data_byte, output bit_count, input ready);
	modport sink (input valid, input op, input data_byte, input bit_count, output ready);
endinterface

interface lsbr_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] value;
	logic        ok;

	modport source (output valid, output value, output ok, input ready);
	modport sink (input valid, input value, input ok, output ready);
endinterface

// ----- rtl/lsbr_core.sv -----
module lsbr_core #(
	parameter int BUFFER_BITS = lsbr_pkg::LSBR_BUFFER_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  lsbr_pkg::op_t        op,
	input  logic [7:0]           data_byte,
	input  logic [5:0]           bit_count,
	output lsbr_pkg::rsp_t       rsp
);
	import lsbr_pkg::*;

	localparam int FILL_W = $clog2(BUFFER_BITS + 1);

	logic [BUFFER_BITS-1:0] store_q;
	logic [FILL_W-1:0]      fill_q;
	logic [BUFFER_BITS-1:0] store_nxt;
	logic [FILL_W-1:0]      fill_nxt;

	logic                   push_ok;
	logic                   read_ok;
	logic [2:0]             left;
	logic [5:0]             shamt;
	logic [31:0]            field;
	logic [BUFFER_BITS-1:0] shifted;
	logic [BUFFER_BITS-1:0] pushed;

	// Check room for one more byte and enough buffered bits for a read
	assign push_ok = ({1'b0, fill_q} + (FILL_W+1)'(BYTE_BITS)) <= (FILL_W+1)'(BUFFER_BITS);
	assign read_ok = (bit_count <= 6'(MAX_FIELD)) && (FILL_W'(bit_count) <= fill_q);
	assign left    = fill_q[2:0];

	// Extract the oldest bits and drop them from the store
	assign shamt   = (op == OP_ALIGN) ? {3'b000, left} : bit_count;
	assign field   = store_q[31:0] & ~({32{1'b1}} << shamt);
	assign shifted = store_q >> shamt;

	// Append the byte above the buffered bits; bits above the fill are zero
	assign pushed  = store_q | (BUFFER_BITS'(data_byte) << fill_q);

	always_comb begin
		store_nxt = store_q;
		fill_nxt  = fill_q;
		rsp.value = '0;
		rsp.ok    = 1'b0;
		unique case (op)
			OP_PUSH: begin
				if (push_ok) begin
					store_nxt = pushed;
					fill_nxt  = fill_q + FILL_W'(BYTE_BITS);
					rsp.ok    = 1'b1;
				end
			end
			OP_READ: begin
				if (read_ok) begin
					store_nxt = shifted;
					fill_nxt  = fill_q - FILL_W'(bit_count);
					rsp.value = field;
					rsp.ok    = 1'b1;
				end
			end
			OP_ALIGN: begin
				store_nxt = shifted;
				fill_nxt  = fill_q - FILL_W'(left);
				rsp.value = field;
				rsp.ok    = 1'b1;
			end
			default: begin
				rsp.ok = 1'b0;
			end
		endcase
	end

	// Advance the buffer state on every accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			fill_q  <= '0;
		end else if (take) begin
			store_q <= store_nxt;
			fill_q  <= fill_nxt;
		end
	end

endmodule

// ----- rtl/lsbr_rsp_reg.sv -----
module lsbr_rsp_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  lsbr_pkg::rsp_t    d,
	output logic              space,
	lsbr_rsp_if.source        rsp
);
	import lsbr_pkg::*;

	logic valid_q;
	rsp_t data_q;

	// Free when empty or when the held word leaves this cycle
	assign space = !valid_q || rsp.ready;

	// Hold the valid flag until the sink takes the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the payload on accept
	always_ff @(posedge clk) begin
		if (take) begin
			data_q <= d;
		end
	end

	assign rsp.valid = valid_q;
	assign rsp.value = data_q.value;
	assign rsp.ok    = data_q.ok;

endmodule

// ----- rtl/lsb_first_bit_reader.sv -----
// Channel | Dir | Word
// --------+-----+-------------------------------------------
// req     | in  | op, data_byte, bit_count
// rsp     | out | value, ok (one result word per request word)
//
// One request word per cycle while req.ready is high; its result is on rsp the cycle after accept.
// The buffer update (barrel shift or byte merge) is combinational and is registered on accept.
// req.ready drops only while a result waits in the output register and
// rsp.ready is low. Reset empties the buffer and the output register.
module lsb_first_bit_reader #(
	parameter int BUFFER_BITS = lsbr_pkg::LSBR_BUFFER_BITS
) (
	input logic         clk,
	input logic         arst_n,
	lsbr_req_if.sink    req,
	lsbr_rsp_if.source  rsp
);
	import lsbr_pkg::*;

	logic take;
	logic space;
	rsp_t result;

	assign req.ready = space;
	assign take      = req.valid && space;

	lsbr_core #(
		.BUFFER_BITS (BUFFER_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.op        (req.op),
		.data_byte (req.data_byte),
		.bit_count (req.bit_count),
		.rsp       (result)
	);

	lsbr_rsp_reg u_rsp_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.d      (result),
		.space  (space),
		.rsp    (rsp)
	);

endmodule

// ----- rtl/lsbr_checker.sv -----
module lsbr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input lsbr_pkg::op_t req_op,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input logic [31:0]   rsp_value,
	input logic          rsp_ok
);
	import lsbr_pkg::*;

	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// Every accepted word shows its result the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> rsp_valid)
		else $error("result missing after accepted request");

	// No request taken while a result is stalled
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("request taken while result stalled");

	// Unused op is refused
	a_bad_op: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_op != OP_PUSH && req_op != OP_READ && req_op != OP_ALIGN)
		|=> !rsp_ok)
		else $error("unused op not refused");

	// Push never returns data
	a_push_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req_op == OP_PUSH) |=> (rsp_value == 32'd0))
		else $error("push returned nonzero value");

	// Stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value) && $stable(rsp_ok)))
		else $error("stalled result changed");

endmodule

bind lsb_first_bit_reader lsbr_checker u_lsbr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_op    (req.op),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_value (rsp.value),
	.rsp_ok    (rsp.ok)
);
